// File: design/svf2x_pkg.sv
// ----------------------------------------------------------------------------
// svf2x_pkg: shared types, constants and fixed point helpers
// Formats, codes and saturation/rescale functions used by the double-sampled
// state variable filter core.
// ----------------------------------------------------------------------------
package svf2x_pkg;

    // sample and state widths
    localparam int SAMPLE_BITS = 16;
    localparam int STATE_BITS  = 32;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int STATE_FRAC  = STATE_BITS - 8;

    // coefficient formats
    localparam int FREQ_W     = 15;
    localparam int DAMP_W     = 18;
    localparam int COEF_FRAC  = 16;
    localparam int MUL_B_W    = DAMP_W + 1;
    localparam int PROD_W     = STATE_BITS + MUL_B_W;
    localparam int PQ_W       = PROD_W - COEF_FRAC;
    localparam int ACC_W      = PQ_W + 1;

    localparam logic [FREQ_W-1:0] FREQ_MAX   = FREQ_W'(16384);
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(12);
    localparam logic [DAMP_W-1:0] DAMP_MAX   = DAMP_W'(131072);

    // input alignment into the state format
    localparam int X_SHIFT = STATE_FRAC - SAMPLE_FRAC;
    localparam int X_SHL   = (X_SHIFT >= 0) ? X_SHIFT : 0;
    localparam int X_SHR   = (X_SHIFT < 0) ? -X_SHIFT : 0;
    localparam int X_W     = STATE_BITS + SAMPLE_BITS;

    // output halving and alignment back into the sample format
    localparam int O_SHIFT = STATE_FRAC - SAMPLE_FRAC + 1;
    localparam int O_SHL   = (O_SHIFT < 0) ? -O_SHIFT : 0;
    localparam int O_SHR   = (O_SHIFT >= 0) ? O_SHIFT : 0;
    localparam int SEL_W   = STATE_BITS + 1;
    localparam int O_W     = SEL_W + SAMPLE_BITS + 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DAMP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ = 2'd0,
        CFG_DAMP = 2'd1,
        CFG_MODE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_LOW   = 3'd0,
        MODE_HIGH  = 3'd1,
        MODE_BAND  = 3'd2,
        MODE_NOTCH = 3'd3,
        MODE_PEAK  = 3'd4
    } t_mode;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DAMP_W-1:0] damp;
        t_mode             mode;
    } t_cfg;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MS_BAND_DAMP = 2'd0,
        MS_BAND_FREQ = 2'd1,
        MS_HIGH_FREQ = 2'd2
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_notch;
        logic     upd_low;
        logic     upd_high;
        logic     upd_band;
        logic     out_load;
    } t_dp_cmd;

    // saturate a widened sum to the state range
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-STATE_BITS:0] top;
        logic signed [STATE_BITS-1:0] res;
        top = v[ACC_W-1:STATE_BITS-1];
        if ((&top) || !(|top)) begin
            res = v[STATE_BITS-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    // align an input sample into the state format
    function automatic logic signed [STATE_BITS-1:0] align_in(
        input logic signed [SAMPLE_BITS-1:0] xs
    );
        logic signed [X_W-1:0] t;
        t = X_W'(xs);
        t = (t <<< X_SHL) >>> X_SHR;
        return t[STATE_BITS-1:0];
    endfunction

    // halve, rescale with floor rounding and saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] scale_out(
        input logic signed [SEL_W-1:0] v
    );
        logic signed [O_W-1:0] t;
        logic [O_W-SAMPLE_BITS:0] top;
        logic signed [SAMPLE_BITS-1:0] res;
        t = O_W'(v);
        t = (t <<< O_SHL) >>> O_SHR;
        top = t[O_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top)) begin
            res = t[SAMPLE_BITS-1:0];
        end else if (t[O_W-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: design/svf2x_cfg.sv
// ----------------------------------------------------------------------------
// svf2x_cfg: configuration registers
// Holds frequency, damping and mode; clamps coefficients and drops unused
// mode codes on write.
// ----------------------------------------------------------------------------
module svf2x_cfg
    import svf2x_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic [FREQ_W-1:0] wr_freq;
    logic [DAMP_W-1:0] wr_damp;
    logic [2:0]        wr_mode;

    assign wr_freq = i_cfg_data[FREQ_W-1:0];
    assign wr_damp = i_cfg_data[DAMP_W-1:0];
    assign wr_mode = i_cfg_data[2:0];

    // register write decode with clamping
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FREQ: n_cfg.freq = (wr_freq > FREQ_MAX) ? FREQ_MAX : wr_freq;
                CFG_DAMP: n_cfg.damp = (wr_damp > DAMP_MAX) ? DAMP_MAX : wr_damp;
                CFG_MODE: begin
                    if (wr_mode <= 3'(MODE_PEAK)) begin
                        n_cfg.mode = t_mode'(wr_mode);
                    end
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq <= FREQ_RESET;
            r_cfg.damp <= DAMP_MAX;
            r_cfg.mode <= MODE_LOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/svf2x_ctrl.sv
// ----------------------------------------------------------------------------
// svf2x_ctrl: sequencing controller
// Steps two filter passes through the shared multiplier and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module svf2x_ctrl
    import svf2x_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL_D = 9'b000000010,
        ST_NOTCH = 9'b000000100,
        ST_MUL_L = 9'b000001000,
        ST_LOW   = 9'b000010000,
        ST_HIGH  = 9'b000100000,
        ST_MUL_B = 9'b001000000,
        ST_BAND  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    logic    r_pass, n_pass;
    logic    r_out_valid, n_out_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free = !r_out_valid || i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        cmd.mul_sel = MS_BAND_DAMP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_x = 1'b1;
                    n_pass     = 1'b0;
                    n_state    = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BAND_DAMP;
                n_state     = ST_NOTCH;
            end
            ST_NOTCH: begin
                cmd.upd_notch = 1'b1;
                n_state       = ST_MUL_L;
            end
            ST_MUL_L: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BAND_FREQ;
                n_state     = ST_LOW;
            end
            ST_LOW: begin
                cmd.upd_low = 1'b1;
                n_state     = ST_HIGH;
            end
            ST_HIGH: begin
                cmd.upd_high = 1'b1;
                n_state      = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_HIGH_FREQ;
                n_state     = ST_BAND;
            end
            ST_BAND: begin
                cmd.upd_band = 1'b1;
                if (r_pass) begin
                    n_state = ST_OUT;
                end else begin
                    n_pass  = 1'b1;
                    n_state = ST_MUL_D;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: design/svf2x_dp.sv
// ----------------------------------------------------------------------------
// svf2x_dp: filter datapath
// Integrator state, one shared coefficient multiplier with a product
// register, saturating adders and the output register.
// ----------------------------------------------------------------------------
module svf2x_dp
    import svf2x_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    logic signed [STATE_BITS-1:0]  r_x;
    logic signed [STATE_BITS-1:0]  r_low;
    logic signed [STATE_BITS-1:0]  r_band;
    logic signed [STATE_BITS-1:0]  r_notch;
    logic signed [STATE_BITS-1:0]  r_high;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;

    logic signed [STATE_BITS-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      n_prod;
    logic signed [PQ_W-1:0]        prod_q;
    logic signed [ACC_W-1:0]       prod_e;
    logic signed [SEL_W-1:0]       sel;

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_BAND_DAMP: begin
                mul_a = r_band;
                mul_b = signed'({1'b0, i_cfg.damp});
            end
            MS_BAND_FREQ: begin
                mul_a = r_band;
                mul_b = signed'({{(MUL_B_W-FREQ_W){1'b0}}, i_cfg.freq});
            end
            MS_HIGH_FREQ: begin
                mul_a = r_high;
                mul_b = signed'({{(MUL_B_W-FREQ_W){1'b0}}, i_cfg.freq});
            end
            default: begin
                mul_a = r_band;
                mul_b = signed'({1'b0, i_cfg.damp});
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    // product scaled by the coefficient fraction, floor rounding
    assign prod_q = r_prod[PROD_W-1:COEF_FRAC];
    assign prod_e = ACC_W'(prod_q);

    // output response select
    always_comb begin
        unique case (i_cfg.mode)
            MODE_LOW:   sel = SEL_W'(r_low);
            MODE_HIGH:  sel = SEL_W'(r_high);
            MODE_BAND:  sel = SEL_W'(r_band);
            MODE_NOTCH: sel = SEL_W'(r_notch);
            MODE_PEAK:  sel = SEL_W'(r_low) - SEL_W'(r_high);
            default:    sel = SEL_W'(r_low);
        endcase
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_band <= '0;
        end else begin
            if (i_cmd.upd_low) begin
                r_low <= sat_state(ACC_W'(r_low) + prod_e);
            end
            if (i_cmd.upd_band) begin
                r_band <= sat_state(ACC_W'(r_band) + prod_e);
            end
        end
    end

    // per-pass working registers and output
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= align_in(i_sample_in);
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.upd_notch) begin
            r_notch <= sat_state(ACC_W'(r_x) - prod_e);
        end
        if (i_cmd.upd_high) begin
            r_high <= sat_state(ACC_W'(r_notch) - ACC_W'(r_low));
        end
        if (i_cmd.out_load) begin
            r_sample_out <= scale_out(sel);
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

// File: design/state_variable_filter_2x_core.sv
// ----------------------------------------------------------------------------
// state_variable_filter_2x_core: double-sampled state variable filter
// Each sample takes an accept step, two passes of seven steps each through the
// single shared multiplier, and an output step that stalls until the output
// register is free; the next sample is accepted only after that output step.
// Reset: integrators cleared, freq 12, damp 2.0, mode lowpass, no output.
// A finished sample waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
module state_variable_filter_2x_core
    import svf2x_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    // configuration registers
    svf2x_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // pass sequencer
    svf2x_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    svf2x_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule
